// ===== hw/rtl/cdq_pkg.sv =====
`default_nettype none

package cdq_pkg;

    // fixed field widths of the request and response words
    localparam int ACT_W     = 3;
    localparam int VAL_W     = 32;
    localparam int POS_W     = 16;
    localparam int STAT_W    = 2;
    localparam int CNT_OUT_W = 9;

    // request codes
    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_READ       = 3'd4
    } action_t;

    // response status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_BAD   = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_MOD  = 2'd1,
        S_FIN  = 2'd2
    } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cdq_ram.sv =====
`default_nettype none

module cdq_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port, holds until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/cdq_mod_unit.sv =====
`default_nettype none

module cdq_mod_unit
    import cdq_pkg::*;
#(
    parameter int DW = 9
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [POS_W-1:0] dividend,
    input  wire logic [DW-1:0]    divisor,
    output logic                  done,
    output logic      [DW-1:0]    rem
);

    localparam int CNT_W = $clog2(POS_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [POS_W-1:0] dvd_reg, dvd_next;
    logic [DW-1:0]    dvs_reg, dvs_next;
    logic [DW-1:0]    rem_reg, rem_next;
    logic [DW:0]      trial;

    // one restoring step per cycle, msb of the dividend first
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg, dvd_reg[POS_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[POS_W-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = DW'(trial - {1'b0, dvs_reg});
            end
            else
            begin
                rem_next = trial[DW-1:0];
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(POS_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/circular_deque_with_indexed_read.sv =====
// Bounded double-ended queue of signed items held in a ring of DEPTH entries.
// Each request word pushes or pops at either end or reads the item at a
// 1-based position that wraps modulo the current count; one response word
// (status, item, count) comes back per request. Pushes and pops go from the
// request straight to the response state S_FIN. A read passes through S_MOD:
// the wrapped index comes from a restoring remainder unit that retires
// one position bit per cycle, followed by one registered ring read. Requests
// are taken one at a time; a response waiting on a stalled output does not
// block acceptance of the next request. The ring is not cleared after reset;
// only entries written by a push are ever read.
`default_nettype none

module circular_deque_with_indexed_read
    import cdq_pkg::*;
#(
    parameter int DEPTH      = 256,
    parameter int ITEM_WIDTH = 32
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic [ACT_W-1:0]        action,
    input  wire logic signed [VAL_W-1:0] value,
    input  wire logic [POS_W-1:0]        position,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic      [STAT_W-1:0]       status,
    output logic signed [VAL_W-1:0]      item,
    output logic      [CNT_OUT_W-1:0]    count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    // ring index add, both operands below DEPTH
    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (AW+1)'(DEPTH))
        begin
            s = s - (AW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    // slot offset of the back item, count known nonzero
    function automatic logic [AW-1:0] cnt_next_m1(input logic [CW-1:0] c);
        logic [CW-1:0] d;
        d = c - 1'b1;
        return d[AW-1:0];
    endfunction

    state_t                   state_reg, state_next;
    logic [AW-1:0]            front_reg, front_next;
    logic [CW-1:0]            cnt_reg, cnt_next;
    status_t                  pend_stat_reg, pend_stat_next;
    logic                     rd_used_reg, rd_used_next;
    logic                     out_valid_reg, out_valid_next;
    logic [STAT_W-1:0]        out_stat_reg, out_stat_next;
    logic [VAL_W-1:0]         out_item_reg, out_item_next;
    logic [CNT_OUT_W-1:0]     out_cnt_reg, out_cnt_next;

    logic                     accept;
    logic                     out_free;
    logic                     is_full;
    logic                     is_empty;
    logic                     mod_start;
    logic                     mod_done;
    logic [CW-1:0]            mod_rem;
    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    logic [ITEM_WIDTH-1:0]    ram_wdata;
    logic                     ram_re;
    logic [AW-1:0]            ram_raddr;
    logic [ITEM_WIDTH-1:0]    ram_rdata;
    logic [AW-1:0]            front_m1;

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign is_full  = (cnt_reg == CW'(DEPTH));
    assign is_empty = (cnt_reg == '0);
    assign front_m1 = (front_reg == '0) ? AW'(DEPTH - 1) : front_reg - 1'b1;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (action == ACT_READ && !is_empty && position != '0)
                    begin
                        state_next = S_MOD;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_MOD:
            begin
                if (mod_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and ring control
    always_comb
    begin
        front_next     = front_reg;
        cnt_next       = cnt_reg;
        pend_stat_next = pend_stat_reg;
        rd_used_next   = rd_used_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_stat_next  = out_stat_reg;
        out_item_next  = out_item_reg;
        out_cnt_next   = out_cnt_reg;
        mod_start      = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = front_m1;
        ram_wdata      = ITEM_WIDTH'(value);
        ram_re         = 1'b0;
        ram_raddr      = front_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    pend_stat_next = ST_OK;
                    rd_used_next   = 1'b0;
                    case (action)
                        ACT_PUSH_FRONT:
                        begin
                            if (is_full)
                            begin
                                pend_stat_next = ST_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = front_m1;
                                front_next = front_m1;
                                cnt_next   = cnt_reg + 1'b1;
                            end
                        end
                        ACT_PUSH_BACK:
                        begin
                            if (is_full)
                            begin
                                pend_stat_next = ST_FULL;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = wrap_add(front_reg, cnt_reg[AW-1:0]);
                                cnt_next  = cnt_reg + 1'b1;
                            end
                        end
                        ACT_POP_FRONT:
                        begin
                            if (is_empty)
                            begin
                                pend_stat_next = ST_EMPTY;
                            end
                            else
                            begin
                                ram_re       = 1'b1;
                                ram_raddr    = front_reg;
                                rd_used_next = 1'b1;
                                front_next   = wrap_add(front_reg, AW'(1));
                                cnt_next     = cnt_reg - 1'b1;
                            end
                        end
                        ACT_POP_BACK:
                        begin
                            if (is_empty)
                            begin
                                pend_stat_next = ST_EMPTY;
                            end
                            else
                            begin
                                ram_re       = 1'b1;
                                ram_raddr    = wrap_add(front_reg, cnt_next_m1(cnt_reg));
                                rd_used_next = 1'b1;
                                cnt_next     = cnt_reg - 1'b1;
                            end
                        end
                        ACT_READ:
                        begin
                            if (is_empty)
                            begin
                                pend_stat_next = ST_EMPTY;
                            end
                            else if (position == '0)
                            begin
                                pend_stat_next = ST_BAD;
                            end
                            else
                            begin
                                mod_start = 1'b1;
                            end
                        end
                        default:
                        begin
                            pend_stat_next = ST_OK;
                        end
                    endcase
                end
            end
            S_MOD:
            begin
                if (mod_done)
                begin
                    ram_re       = 1'b1;
                    ram_raddr    = wrap_add(front_reg, mod_rem[AW-1:0]);
                    rd_used_next = 1'b1;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_stat_next  = pend_stat_reg;
                    out_item_next  = rd_used_reg ? VAL_W'(ram_rdata) : '0;
                    out_cnt_next   = CNT_OUT_W'(cnt_reg);
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg && out_stall;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            front_reg     <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_stat_reg <= pend_stat_next;
        rd_used_reg   <= rd_used_next;
        out_stat_reg  <= out_stat_next;
        out_item_reg  <= out_item_next;
        out_cnt_reg   <= out_cnt_next;
    end

    // wrapped read index: (position - 1) mod count
    cdq_mod_unit #(
        .DW (CW)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (position - 1'b1),
        .divisor  (cnt_reg),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    // ring store
    cdq_ram #(
        .DEPTH (DEPTH),
        .WIDTH (ITEM_WIDTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign status    = out_stat_reg;
    assign item      = out_item_reg;
    assign count     = out_cnt_reg;

endmodule

`default_nettype wire
